[sv/humidity_sensor_read_sequencer_assert.svh]
// Assertion macros for the humidity sensor read sequencer checker.
// Plain text macros only; users include this file by its bare name.
`ifndef HUMIDITY_SENSOR_READ_SEQUENCER_ASSERT_SVH
`define HUMIDITY_SENSOR_READ_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HSRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hsrs_pkg.sv]
// Shared types, codes and constants of the humidity sensor read sequencer.
// Holds the CRC-8 helper used by the conversion unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsrs_pkg;

  // Field widths
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned TIMEOUT_W    = 16;
  localparam int unsigned FAIL_W       = 8;
  localparam int unsigned PHASE_W      = 2;
  localparam int unsigned FAULT_W      = 2;
  localparam int unsigned TEMP_W       = 15;
  localparam int unsigned HUM_W        = 14;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned FRAME_BYTES  = 6;
  localparam int unsigned TIMER_BITS_DEF = 16;

  // Item commands
  localparam logic [CMD_W-1:0] CMD_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BYTE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DONE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // Measurement phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_MEAS  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_READY = 2'd3;

  // Fault codes
  localparam logic [FAULT_W-1:0] FAULT_NONE    = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_HW      = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_CMD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd2;

  // Configuration reset values
  localparam logic [7:0]           MEASURE_CMD_RST = 8'd253;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 16'd10;
  localparam logic [FAIL_W-1:0]    MAX_RETRIES_RST = 8'd3;

  // Scaling: value = floor(span * raw / 65535) - offset, in hundredths
  localparam logic [14:0]        TEMP_SPAN   = 15'd17500;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic [13:0]        HUM_SPAN    = 14'd12500;
  localparam logic [HUM_W-1:0]   HUM_OFFSET  = 14'd600;
  localparam logic [HUM_W-1:0]   HUM_MAX     = 14'd10000;

  // CRC-8, polynomial 0x31, preset 0xFF
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic                     temp_ok;
    logic                     hum_ok;
  } conv_t;

  // One byte through the CRC register, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
    end
    return crc;
  endfunction

  // CRC of a two-byte word
  function automatic logic [7:0] crc8_word(input logic [7:0] b0, input logic [7:0] b1);
    return crc8_byte(crc8_byte(CRC_INIT, b0), b1);
  endfunction

endpackage

`default_nettype wire

[sv/hsrs_conv.sv]
// Frame conversion: CRC check and scaling of the temperature and humidity words.
// Depends on hsrs_pkg for the frame and result types and the scale constants.
`timescale 1ns / 1ps
`default_nettype none

module hsrs_conv (
  input  hsrs_pkg::frame_t frame_i,
  output hsrs_pkg::conv_t  conv_o
);
  import hsrs_pkg::*;

  // floor(x / 65535) for x below 2^31: add the high half back, round up by one
  function automatic logic [15:0] div_full_scale(input logic [31:0] x);
    logic [32:0] s;
    s = 33'(x) + 33'(x[31:16]) + 33'd1;
    return s[31:16];
  endfunction

  logic [15:0]        t_raw;
  logic [15:0]        h_raw;
  logic               t_ok;
  logic               h_ok;
  logic [31:0]        t_prod;
  logic [31:0]        h_prod;
  logic [15:0]        t_q;
  logic [15:0]        h_q;
  logic signed [15:0] t_sum;
  logic [HUM_W-1:0]   h_shift;
  logic [HUM_W-1:0]   h_val;

  // Words and their checks
  assign t_raw = {frame_i[0], frame_i[1]};
  assign h_raw = {frame_i[3], frame_i[4]};
  assign t_ok  = (crc8_word(frame_i[0], frame_i[1]) == frame_i[2]);
  assign h_ok  = (crc8_word(frame_i[3], frame_i[4]) == frame_i[5]);

  // Scale to hundredths
  assign t_prod = 32'(t_raw) * 32'(TEMP_SPAN);
  assign h_prod = 32'(h_raw) * 32'(HUM_SPAN);
  assign t_q    = div_full_scale(t_prod);
  assign h_q    = div_full_scale(h_prod);

  // Temperature: quotient is at most 17500, so it fits 15 bits
  assign t_sum = $signed({1'b0, t_q[14:0]}) - TEMP_OFFSET;

  // Humidity: quotient is at most 12500; remove offset and clamp to 0..10000
  assign h_shift = h_q[HUM_W-1:0] - HUM_OFFSET;
  always_comb begin
    if (h_q[HUM_W-1:0] < HUM_OFFSET) begin
      h_val = '0;
    end else if (h_shift > HUM_MAX) begin
      h_val = HUM_MAX;
    end else begin
      h_val = h_shift;
    end
  end

  // A failed check reports zero
  assign conv_o.temperature = t_ok ? t_sum[TEMP_W-1:0] : '0;
  assign conv_o.humidity    = h_ok ? h_val : '0;
  assign conv_o.temp_ok     = t_ok;
  assign conv_o.hum_ok      = h_ok;

endmodule

`default_nettype wire

[sv/humidity_sensor_read_sequencer.sv]
// Top level of the humidity/temperature sensor read sequencer.
// Depends on hsrs_pkg and hsrs_conv.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock and returns one result item for each: the item is
// captured in an input register, the state update and frame conversion (CRC-8
// check and a constant multiply per word) run in one pass of logic, and the
// outcome lands in the result register, which drives the result ports.
// Throughput is one item per cycle, limited only by out_stall; an input item is
// still taken while a finished result waits. No start-up sweep after reset.
// TIMER_BITS sets the width of the tick counter, which saturates at its maximum.
module humidity_sensor_read_sequencer #(
  parameter int unsigned TIMER_BITS = hsrs_pkg::TIMER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [hsrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsrs_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hsrs_pkg::CMD_W-1:0]          in_cmd,
  input  logic                                in_bus_ok,
  input  logic [7:0]                          in_rx_byte,
  input  logic [hsrs_pkg::IDX_W-1:0]          in_byte_index,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_accepted,
  output logic [7:0]                          out_write_byte,
  output logic                                out_issue_read,
  output logic [hsrs_pkg::PHASE_W-1:0]        out_phase,
  output logic [hsrs_pkg::FAULT_W-1:0]        out_fault_code,
  output logic signed [hsrs_pkg::TEMP_W-1:0]  out_temperature_centi,
  output logic [hsrs_pkg::HUM_W-1:0]          out_humidity_centi,
  output logic                                out_temp_crc_ok,
  output logic                                out_hum_crc_ok,
  output logic                                out_new_data
);
  import hsrs_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // Configuration registers
  logic [7:0]           measure_cmd_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [FAIL_W-1:0]    max_retries_r;

  // Input register
  logic                 s1_valid_r;
  logic [CMD_W-1:0]     s1_cmd_r;
  logic                 s1_bus_ok_r;
  logic [7:0]           s1_rx_byte_r;
  logic [IDX_W-1:0]     s1_idx_r;

  // Sequencer state
  logic [PHASE_W-1:0]    phase_r,   phase_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [FAIL_W-1:0]     fail_r,    fail_nxt;
  logic [FAULT_W-1:0]    fault_r,   fault_nxt;
  frame_t                rx_buf_r,  rx_buf_nxt;
  conv_t                 meas_r,    meas_nxt;

  // Per-item result flags
  logic       out_valid_r;
  logic       accepted_r,  accepted_nxt;
  logic [7:0] wbyte_r,     wbyte_nxt;
  logic       issue_r,     issue_nxt;
  logic       fresh_r,     fresh_nxt;

  logic                  s1_adv;
  logic                  s1_fire;
  logic                  in_take;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  timed_out;
  logic                  fail_hit;
  logic [FAULT_W-1:0]    fail_code;
  logic [FAIL_W-1:0]     fail_after;
  conv_t                 conv;

  // Handshake: input stage moves whenever the result register is free
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  hsrs_conv u_conv (
    .frame_i (rx_buf_r),
    .conv_o  (conv)
  );

  // Saturating tick counter and timeout compare
  assign elapsed_inc = (elapsed_r != TIMER_MAX) ? elapsed_r + TIMER_BITS'(1) : elapsed_r;
  assign timed_out   = CMP_W'(elapsed_inc) > CMP_W'(timeout_r);

  // Item decode and state update
  always_comb begin
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    fail_nxt     = fail_r;
    fault_nxt    = fault_r;
    rx_buf_nxt   = rx_buf_r;
    meas_nxt     = meas_r;
    accepted_nxt = 1'b0;
    wbyte_nxt    = '0;
    issue_nxt    = 1'b0;
    fresh_nxt    = 1'b0;
    fail_hit     = 1'b0;
    fail_code    = FAULT_HW;
    case (s1_cmd_r)
      CMD_START: begin
        if (phase_r == PH_IDLE) begin
          wbyte_nxt = measure_cmd_r;
          if (s1_bus_ok_r) begin
            phase_nxt    = PH_MEAS;
            elapsed_nxt  = '0;
            fail_nxt     = '0;
            accepted_nxt = 1'b1;
          end else begin
            fail_hit = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (phase_r == PH_MEAS && timed_out) begin
          issue_nxt = 1'b1;
          if (s1_bus_ok_r) begin
            phase_nxt   = PH_WAIT;
            elapsed_nxt = '0;
          end else begin
            phase_nxt = PH_IDLE;
            fail_hit  = 1'b1;
          end
        end else if (phase_r == PH_WAIT && timed_out) begin
          phase_nxt = PH_IDLE;
          fail_hit  = 1'b1;
          fail_code = FAULT_TIMEOUT;
        end
      end
      CMD_BYTE: begin
        if (32'(s1_idx_r) < FRAME_BYTES) begin
          rx_buf_nxt[s1_idx_r] = s1_rx_byte_r;
        end
      end
      CMD_DONE: begin
        // passes through data ready and back to idle within the item
        if (phase_r == PH_WAIT) begin
          phase_nxt = PH_IDLE;
          meas_nxt  = conv;
          fresh_nxt = 1'b1;
        end
      end
      CMD_CLEAR: begin
        fault_nxt = FAULT_NONE;
        fail_nxt  = '0;
      end
      default: begin
      end
    endcase

    // Failure bookkeeping: count up to one past the limit, then latch the code
    fail_after = (fail_r <= max_retries_r && fail_r != {FAIL_W{1'b1}})
                 ? fail_r + FAIL_W'(1) : fail_r;
    if (fail_hit) begin
      fail_nxt = fail_after;
      if (fail_after > max_retries_r) begin
        fault_nxt = fail_code;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measure_cmd_r <= MEASURE_CMD_RST;
      timeout_r     <= TIMEOUT_RST;
      max_retries_r <= MAX_RETRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEASURE_CMD: measure_cmd_r <= cfg_data[7:0];
        CFG_TIMEOUT:     timeout_r     <= cfg_data[TIMEOUT_W-1:0];
        CFG_MAX_RETRIES: max_retries_r <= cfg_data[FAIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r     <= in_cmd;
      s1_bus_ok_r  <= in_bus_ok;
      s1_rx_byte_r <= in_rx_byte;
      s1_idx_r     <= in_byte_index;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      fail_r      <= '0;
      fault_r     <= FAULT_NONE;
      rx_buf_r    <= '0;
      meas_r      <= '0;
    end else begin
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        phase_r   <= phase_nxt;
        elapsed_r <= elapsed_nxt;
        fail_r    <= fail_nxt;
        fault_r   <= fault_nxt;
        rx_buf_r  <= rx_buf_nxt;
        meas_r    <= meas_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      accepted_r <= accepted_nxt;
      wbyte_r    <= wbyte_nxt;
      issue_r    <= issue_nxt;
      fresh_r    <= fresh_nxt;
    end
  end

  // Result ports
  assign out_valid             = out_valid_r;
  assign out_accepted          = accepted_r;
  assign out_write_byte        = wbyte_r;
  assign out_issue_read        = issue_r;
  assign out_phase             = phase_r;
  assign out_fault_code        = fault_r;
  assign out_temperature_centi = meas_r.temperature;
  assign out_humidity_centi    = meas_r.humidity;
  assign out_temp_crc_ok       = meas_r.temp_ok;
  assign out_hum_crc_ok        = meas_r.hum_ok;
  assign out_new_data          = fresh_r;

endmodule

`default_nettype wire

[sv/hsrs_checker.sv]
// Port-level checker for the humidity sensor read sequencer, bound to the top.
// Depends on hsrs_pkg and humidity_sensor_read_sequencer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "humidity_sensor_read_sequencer_assert.svh"

module hsrs_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic                                out_accepted,
  input wire logic                                out_issue_read,
  input wire logic [hsrs_pkg::PHASE_W-1:0]        out_phase,
  input wire logic                                out_new_data,
  input wire logic signed [hsrs_pkg::TEMP_W-1:0]  out_temperature_centi,
  input wire logic [hsrs_pkg::HUM_W-1:0]          out_humidity_centi,
  input wire logic                                out_temp_crc_ok
);
  import hsrs_pkg::*;

  // a conversion always ends the measurement
  `HSRS_ASSERT_SAME(a_conv_idle, clk, rst_n, out_valid && out_new_data, out_phase == PH_IDLE, "conversion did not return to idle")

  // an accepted start leaves the block measuring
  `HSRS_ASSERT_SAME(a_start_meas, clk, rst_n, out_valid && out_accepted, out_phase == PH_MEAS, "accepted start not measuring")

  // an issued read either waits for data or has failed back to idle
  `HSRS_ASSERT_SAME(a_read_phase, clk, rst_n, out_valid && out_issue_read, out_phase == PH_WAIT || out_phase == PH_IDLE, "bad phase after read")

  // failed temperature check reports zero; humidity stays in range
  `HSRS_ASSERT_SAME(a_values, clk, rst_n, out_valid, (out_temp_crc_ok || out_temperature_centi == 0) && out_humidity_centi <= HUM_MAX, "result value out of contract")

  // a stalled result is not dropped
  `HSRS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind humidity_sensor_read_sequencer hsrs_checker u_hsrs_checker (.*);

`default_nettype wire

[tb/hsrs_checker.sv]
// Checker for the humidity sensor read sequencer: predicts each result item from
// the accepted input items and register writes, and compares them in order.
// Depends on hsrs_pkg; also holds the frame CRC package used by the stimulus.
`timescale 1ns / 1ps

// CRC-8 of one 16-bit data word, bit by bit, MSB first
package hsrs_frame_pkg;

  function automatic logic [7:0] word_crc(input logic [15:0] word);
    logic [7:0] crc;
    crc = hsrs_pkg::CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      if (crc[7] ^ word[i]) crc = {crc[6:0], 1'b0} ^ hsrs_pkg::CRC_POLY;
      else crc = {crc[6:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

module hsrs_scoreboard #(
  parameter int unsigned TIMER_BITS = hsrs_pkg::TIMER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hsrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsrs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [hsrs_pkg::CMD_W-1:0]          in_cmd,
  input  logic                                in_bus_ok,
  input  logic [7:0]                          in_rx_byte,
  input  logic [hsrs_pkg::IDX_W-1:0]          in_byte_index,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_accepted,
  input  logic [7:0]                          out_write_byte,
  input  logic                                out_issue_read,
  input  logic [hsrs_pkg::PHASE_W-1:0]        out_phase,
  input  logic [hsrs_pkg::FAULT_W-1:0]        out_fault_code,
  input  logic signed [hsrs_pkg::TEMP_W-1:0]  out_temperature_centi,
  input  logic [hsrs_pkg::HUM_W-1:0]          out_humidity_centi,
  input  logic                                out_temp_crc_ok,
  input  logic                                out_hum_crc_ok,
  input  logic                                out_new_data,
  output int                                  errors,
  output int                                  pending
);
  import hsrs_pkg::*;
  import hsrs_frame_pkg::*;

  localparam longint RAW_FULL = 65535;
  localparam logic [TIMER_BITS-1:0] TIMER_FULL = '1;

  typedef struct packed {
    logic                     accepted;
    logic [7:0]               write_byte;
    logic                     issue_read;
    logic [PHASE_W-1:0]       phase;
    logic [FAULT_W-1:0]       fault;
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic                     temp_ok;
    logic                     hum_ok;
    logic                     new_data;
  } readout_t;

  readout_t readout_q[$];

  // register copies
  logic [7:0]           measure_cmd_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [7:0]           retries_q;

  // sequencer state
  logic [PHASE_W-1:0]       phase_st;
  logic [TIMER_BITS-1:0]    elapsed_st;
  logic [7:0]               fails_st;
  logic [FAULT_W-1:0]       fault_st;
  logic [7:0]               frame_st [FRAME_BYTES];
  logic signed [TEMP_W-1:0] temp_st;
  logic [HUM_W-1:0]         hum_st;
  logic                     temp_ok_st;
  logic                     hum_ok_st;

  // count one bus failure; past the retry budget the fault takes its code
  function automatic void count_failure(input logic [FAULT_W-1:0] code);
    if (fails_st <= retries_q && fails_st != 8'hFF) fails_st++;
    if (fails_st > retries_q) fault_st = code;
  endfunction

  // frame to hundredths; a word with a bad CRC reads as zero
  function automatic void convert_frame();
    logic [15:0] traw;
    logic [15:0] hraw;
    longint value;
    traw = {frame_st[0], frame_st[1]};
    hraw = {frame_st[3], frame_st[4]};
    temp_ok_st = (word_crc(traw) == frame_st[2]);
    hum_ok_st = (word_crc(hraw) == frame_st[5]);
    temp_st = '0;
    hum_st = '0;
    if (temp_ok_st) begin
      value = longint'(TEMP_SPAN) * longint'(traw) / RAW_FULL - longint'(TEMP_OFFSET);
      temp_st = TEMP_W'(value);
    end
    if (hum_ok_st) begin
      value = longint'(HUM_SPAN) * longint'(hraw) / RAW_FULL - longint'(HUM_OFFSET);
      if (value < 0) value = 0;
      else if (value > longint'(HUM_MAX)) value = longint'(HUM_MAX);
      hum_st = HUM_W'(value);
    end
  endfunction

  // advance the state by one input item and return the result it gives
  function automatic readout_t predict_readout(input logic [CMD_W-1:0] cmd, input logic ok,
                                               input logic [7:0] rx,
                                               input logic [IDX_W-1:0] idx);
    readout_t r;
    r = '0;
    case (cmd)
      CMD_START: begin
        // refused outright while a measurement is under way
        if (phase_st == PH_IDLE) begin
          r.write_byte = measure_cmd_q;
          if (ok) begin
            phase_st = PH_MEAS;
            elapsed_st = '0;
            fails_st = '0;
            r.accepted = 1'b1;
          end else begin
            count_failure(FAULT_HW);
          end
        end
      end
      CMD_TICK: begin
        if (elapsed_st != TIMER_FULL) elapsed_st++;
        if (phase_st == PH_MEAS && elapsed_st > timeout_q) begin
          r.issue_read = 1'b1;
          if (ok) begin
            phase_st = PH_WAIT;
            elapsed_st = '0;
          end else begin
            phase_st = PH_IDLE;
            count_failure(FAULT_HW);
          end
        end else if (phase_st == PH_WAIT && elapsed_st > timeout_q) begin
          phase_st = PH_IDLE;
          count_failure(FAULT_TIMEOUT);
        end
      end
      CMD_BYTE: begin
        if (idx < FRAME_BYTES) frame_st[idx] = rx;
      end
      CMD_DONE: begin
        // ready phase is passed through within the item
        if (phase_st == PH_WAIT) begin
          convert_frame();
          r.new_data = 1'b1;
          phase_st = PH_IDLE;
        end
      end
      CMD_CLEAR: begin
        fault_st = FAULT_NONE;
        fails_st = '0;
      end
      default: ;
    endcase
    r.phase = phase_st;
    r.fault = fault_st;
    r.temperature = temp_st;
    r.humidity = hum_st;
    r.temp_ok = temp_ok_st;
    r.hum_ok = hum_ok_st;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    readout_t want;
    readout_t got;
    if (!rst_n) begin
      measure_cmd_q = MEASURE_CMD_RST;
      timeout_q = TIMEOUT_RST;
      retries_q = MAX_RETRIES_RST;
      phase_st = PH_IDLE;
      elapsed_st = '0;
      fails_st = '0;
      fault_st = FAULT_NONE;
      for (int i = 0; i < FRAME_BYTES; i++) frame_st[i] = '0;
      temp_st = '0;
      hum_st = '0;
      temp_ok_st = 1'b0;
      hum_ok_st = 1'b0;
      readout_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEASURE_CMD: measure_cmd_q = cfg_data[7:0];
          CFG_TIMEOUT:     timeout_q = cfg_data[TIMEOUT_W-1:0];
          CFG_MAX_RETRIES: retries_q = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        readout_q.push_back(predict_readout(in_cmd, in_bus_ok, in_rx_byte, in_byte_index));
      if (out_valid && !out_stall) begin
        got = {out_accepted, out_write_byte, out_issue_read, out_phase, out_fault_code,
               out_temperature_centi, out_humidity_centi, out_temp_crc_ok, out_hum_crc_ok,
               out_new_data};
        if (readout_q.size() == 0) begin
          errors++;
          $display("%0t: result item with nothing expected, got %h", $time, got);
        end else begin
          want = readout_q.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("write_byte", want.write_byte, got.write_byte);
          check_field("issue_read", want.issue_read, got.issue_read);
          check_field("phase", want.phase, got.phase);
          check_field("fault_code", want.fault, got.fault);
          check_field("temperature_centi", want.temperature, got.temperature);
          check_field("humidity_centi", want.humidity, got.humidity);
          check_field("temp_crc_ok", want.temp_ok, got.temp_ok);
          check_field("hum_crc_ok", want.hum_ok, got.hum_ok);
          check_field("new_data", want.new_data, got.new_data);
        end
      end
    end
    pending = readout_q.size();
  end

endmodule

[tb/tb_humidity_sensor_read_sequencer.sv]
// Top of the humidity sensor read sequencer testbench: clock, reset, register
// writes and item stimulus with random idling. Depends on hsrs_pkg, hsrs_frame_pkg, hsrs_scoreboard.
`timescale 1ns / 1ps

module tb_humidity_sensor_read_sequencer;
  import hsrs_pkg::*;
  import hsrs_frame_pkg::*;

  // codes outside the block's own set
  localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0]     CMD_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  // frame positions past the last byte
  localparam logic [IDX_W-1:0]     IDX_PAST_END = 3'd6;
  localparam logic [IDX_W-1:0]     IDX_TOP      = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CMD_W-1:0]       in_cmd = '0;
  logic                   in_bus_ok = 1'b0;
  logic [7:0]             in_rx_byte = '0;
  logic [IDX_W-1:0]       in_byte_index = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_accepted;
  logic [7:0]             out_write_byte;
  logic                   out_issue_read;
  logic [PHASE_W-1:0]     out_phase;
  logic [FAULT_W-1:0]     out_fault_code;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic [HUM_W-1:0]       out_humidity_centi;
  logic                   out_temp_crc_ok;
  logic                   out_hum_crc_ok;
  logic                   out_new_data;

  int errors;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int cur_timeout = TIMEOUT_RST;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  humidity_sensor_read_sequencer u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_bus_ok(in_bus_ok),
    .in_rx_byte(in_rx_byte), .in_byte_index(in_byte_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_accepted(out_accepted),
    .out_write_byte(out_write_byte), .out_issue_read(out_issue_read),
    .out_phase(out_phase), .out_fault_code(out_fault_code),
    .out_temperature_centi(out_temperature_centi), .out_humidity_centi(out_humidity_centi),
    .out_temp_crc_ok(out_temp_crc_ok), .out_hum_crc_ok(out_hum_crc_ok),
    .out_new_data(out_new_data)
  );

  hsrs_scoreboard u_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_bus_ok(in_bus_ok),
    .in_rx_byte(in_rx_byte), .in_byte_index(in_byte_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_accepted(out_accepted),
    .out_write_byte(out_write_byte), .out_issue_read(out_issue_read),
    .out_phase(out_phase), .out_fault_code(out_fault_code),
    .out_temperature_centi(out_temperature_centi), .out_humidity_centi(out_humidity_centi),
    .out_temp_crc_ok(out_temp_crc_ok), .out_hum_crc_ok(out_hum_crc_ok),
    .out_new_data(out_new_data),
    .errors(errors), .pending(pending)
  );

  // result side back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // one item, with random idle cycles ahead of it; returns at the next falling edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic ok,
                           input logic [7:0] rx, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_bus_ok <= ok;
    in_rx_byte <= rx;
    in_byte_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // item whose data byte and position are don't-care
  task automatic send_op(input logic [CMD_W-1:0] cmd, input logic ok);
    send_item(cmd, ok, 8'($urandom), IDX_W'($urandom));
  endtask

  // hold off until every result is back
  task automatic wait_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_TIMEOUT) cur_timeout = value;
  endtask

  // enough failing ticks to drop out of any measurement back to idle
  task automatic settle_idle();
    repeat (cur_timeout + 1) send_op(CMD_TICK, 1'b0);
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // six frame bytes, sometimes out of order, CRC bytes optionally broken
  task automatic send_frame(input logic [15:0] traw, input logic [15:0] hraw,
                            input logic bad_t, input logic bad_h);
    logic [7:0] frame [FRAME_BYTES];
    int order [FRAME_BYTES];
    int j;
    int swap;
    frame[0] = traw[15:8];
    frame[1] = traw[7:0];
    frame[2] = word_crc(traw) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
    frame[3] = hraw[15:8];
    frame[4] = hraw[7:0];
    frame[5] = word_crc(hraw) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
    for (int i = 0; i < FRAME_BYTES; i++) order[i] = i;
    if ($urandom_range(3) == 0) begin
      for (int i = FRAME_BYTES - 1; i > 0; i--) begin
        j = $urandom_range(i);
        swap = order[i];
        order[i] = order[j];
        order[j] = swap;
      end
    end
    for (int i = 0; i < FRAME_BYTES; i++)
      send_item(CMD_BYTE, 1'($urandom), frame[order[i]], IDX_W'(order[i]));
  endtask

  // start, wait out the timer, read, fill the frame, convert
  task automatic run_measurement();
    logic start_ok;
    logic read_ok;
    start_ok = ($urandom_range(15) != 0);
    read_ok = ($urandom_range(15) != 0);
    send_op(CMD_START, start_ok);
    if (start_ok) begin
      repeat (cur_timeout) send_op(CMD_TICK, 1'($urandom));
      send_op(CMD_TICK, read_ok);
      if (read_ok) begin
        send_frame(pick_raw(), pick_raw(), $urandom_range(7) == 0, $urandom_range(7) == 0);
        // now and then the data never arrives and the wait times out
        if ($urandom_range(9) == 0) repeat (cur_timeout + 1) send_op(CMD_TICK, 1'($urandom));
        else send_op(CMD_DONE, 1'($urandom));
      end
    end
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(19))
        0: send_op(CMD_CLEAR, 1'($urandom));
        1: wait_results();
        2, 3, 4, 5: begin
          repeat ($urandom_range(1, 4)) send_op(CMD_W'($urandom_range(CMD_SPARE_HI)), 1'($urandom));
        end
        default: run_measurement();
      endcase
    end
  endtask

  initial begin
    send_idle_pct = 13;
    recv_stall_pct = 60;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: no retries, one-tick timeout, all-ones command
    write_reg(CFG_MEASURE_CMD, 8'hFF);
    write_reg(CFG_TIMEOUT, 1);
    write_reg(CFG_MAX_RETRIES, 0);
    write_reg(CFG_SPARE, 16'hFFFF);
    send_item(CMD_START, 1'b0, 8'hFF, IDX_TOP);   // failed write latches hardware fault
    send_item(CMD_CLEAR, 1'b1, 8'h00, 3'd0);
    send_op(CMD_START, 1'b1);
    send_op(CMD_START, 1'b1);                     // busy: refused
    send_op(CMD_TICK, 1'b1);
    send_op(CMD_TICK, 1'b1);                      // read issued
    send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0);   // hottest, humidity clamped low
    send_item(CMD_BYTE, 1'b1, 8'hA5, IDX_PAST_END);
    send_item(CMD_BYTE, 1'b1, 8'h5A, IDX_TOP);
    send_op(CMD_DONE, 1'b1);
    send_op(CMD_DONE, 1'b1);                      // not waiting: ignored
    send_op(CMD_SPARE_LO, 1'b1);
    send_op(CMD_SPARE_HI, 1'b0);
    send_op(CMD_START, 1'b1);
    send_op(CMD_TICK, 1'b0);
    send_op(CMD_TICK, 1'b1);
    send_op(CMD_TICK, 1'b1);
    send_op(CMD_TICK, 1'b1);                      // data timeout
    send_op(CMD_START, 1'b0);                     // hardware fault replaces timeout
    wait_results();

    // first phase: sender idles a little, receiver a lot
    write_reg(CFG_MEASURE_CMD, 8'h00);
    write_reg(CFG_TIMEOUT, 0);
    write_reg(CFG_MAX_RETRIES, 2);
    random_traffic(100);
    wait_results();

    // second phase: the other way round; fail count runs into saturation
    send_idle_pct = 60;
    recv_stall_pct = 13;
    settle_idle();
    wait_results();
    write_reg(CFG_MAX_RETRIES, 254);
    write_reg(CFG_TIMEOUT, 3);
    write_reg(CFG_MEASURE_CMD, 8'($urandom));
    repeat (260) send_op(CMD_START, 1'b0);
    send_op(CMD_START, 1'b1);
    send_op(CMD_CLEAR, 1'b0);
    random_traffic(100);
    wait_results();

    // third phase: no idling; full-scale timeout holds the read off
    send_idle_pct = 0;
    recv_stall_pct = 0;
    settle_idle();
    wait_results();
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    send_op(CMD_START, 1'b1);
    repeat (8) send_op(CMD_TICK, 1'($urandom));       // full-scale timeout never passes
    wait_results();
    write_reg(CFG_TIMEOUT, 4);
    send_op(CMD_TICK, 1'b1);                          // count already past: read issued
    send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0);       // coldest, humidity clamped high
    send_op(CMD_DONE, 1'b1);
    wait_results();
    write_reg(CFG_TIMEOUT, 10);
    write_reg(CFG_MAX_RETRIES, 0);
    write_reg(CFG_MEASURE_CMD, 8'h5A);
    random_traffic(100);

    wait_results();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/hsrs_pkg.sv
sv/hsrs_conv.sv
sv/humidity_sensor_read_sequencer.sv
sv/hsrs_checker.sv
tb/hsrs_checker.sv
tb/tb_humidity_sensor_read_sequencer.sv
